// ===== rtl/imu_tilt_complementary_filter_top_macros.svh =====
// Assertion helpers for the tilt filter. Both expect clk and rst_n in scope.
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tcf same-cycle check failed");
`define TCF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tcf next-cycle check failed");
`else
`define TCF_ASSERT_NOW(lbl, pre, post)
`define TCF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/tcf_pkg.sv =====
package tcf_pkg;

  localparam int XW       = 34;  // CORDIC vector width
  localparam int TAB_LEN  = 24;
  localparam int PRESCALE = 14;

  localparam logic [16:0]        ALPHA_ONE   = 17'd65536;
  localparam logic [16:0]        BLEND_RESET = 17'd63898;
  localparam logic [14:0]        ROLL_LIM    = 15'd23040;
  localparam logic [14:0]        PITCH_LIM   = 15'd11520;
  localparam logic signed [17:0] DEG_SCALE   = 18'sd46080;

  localparam logic [0:0] REG_BLEND = 1'b0;
  localparam logic [0:0] REG_RANGE = 1'b1;

  typedef logic [31:0] turn32_t;

  // atan(2^-i) in 2^-32 turn
  localparam turn32_t ATAN_TURN32 [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic        [15:0] step_time;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] x;
    logic [14:0]          lim;
  } cordic_req_t;

  typedef enum logic [2:0] {
    K_IDLE, K_ROLL_GO, K_ROLL, K_PITCH_GO, K_PITCH, K_FUSE, K_BLEND, K_EMIT
  } back_state_t;

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_MUL, C_RND} cordic_state_t;

  typedef enum logic [2:0] {
    BL_IDLE, BL_AF, BL_AA, BL_AR, BL_DT, BL_SUM, BL_RND
  } blend_state_t;

  // table entry rounded to the configured angle resolution
  function automatic logic [32:0] atan_entry(logic [4:0] idx, int abits);
    logic [32:0] t;
    int          sh;
    t  = {1'b0, ATAN_TURN32[idx]};
    sh = 32 - abits;
    if (sh == 0) return t;
    return (t + (33'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic signed [XW-1:0] prescale(logic signed [15:0] v);
    logic signed [XW-1:0] w;
    w = XW'(v);
    return w <<< PRESCALE;
  endfunction

endpackage

// ===== rtl/imu_tilt_complementary_filter_top.sv =====
// Roll/pitch tilt estimator. Each request carries one raw accelerometer and gyro
// sample plus a time step; the block returns the accelerometer roll and pitch
// (CORDIC atan2, 1/128 degree) and the complementary-filtered angles. A zero
// step leaves the filter untouched, the first nonzero step seeds it from the
// accelerometer, and fused angles read 0 until then (out_tuser marks seeded).
// One request is worked at a time: the bit-serial square root for pitch runs
// beside the roll CORDIC pass, then the pitch pass and a six-step multiply
// sequence for the blend follow. A two-entry queue takes new requests while
// one is worked, and a result register holds the finished result until it
// is taken.
// Write blend_weight and gyro_range only while no request is in flight.
`include "imu_tilt_complementary_filter_top_macros.svh"

module imu_tilt_complementary_filter_top import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accel_x, accel_y, accel_z, gyro_x_raw, gyro_y_raw, step_time
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accel_roll, accel_pitch, fused_roll, fused_pitch, zero pad
  output logic [63:0] out_tdata,
  // seeded
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [16:0] cfg_wr_data
);

  logic [16:0] blend_weight_r, alpha;
  logic [2:0]  gyro_range_r;
  item_t       in_item, head;
  logic        head_valid, pop;

  // register writes: blend weight (Q1.16, 1.0 = 65536) and gyro range code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_RESET;
      gyro_range_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_BLEND: blend_weight_r <= cfg_wr_data;
        REG_RANGE: gyro_range_r   <= cfg_wr_data[2:0];
        default: ;
      endcase
    end
  end

  // weights above one act as one
  assign alpha = (blend_weight_r > ALPHA_ONE) ? ALPHA_ONE : blend_weight_r;

  // unpack the request, first field in the low bits
  assign in_item.accel_x    = in_tdata[15:0];
  assign in_item.accel_y    = in_tdata[31:16];
  assign in_item.accel_z    = in_tdata[47:32];
  assign in_item.gyro_x_raw = in_tdata[63:48];
  assign in_item.gyro_y_raw = in_tdata[79:64];
  assign in_item.step_time  = in_tdata[95:80];

  // front: hold up to two requests ahead of the worker
  tcf_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .pop, .head_valid, .head
  );

  // back: angle extraction, filter update and result register
  tcf_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk, .rst_n, .head_valid, .head, .pop, .alpha, .gyro_range(gyro_range_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // once seeded, the filter never reports unseeded again
  `TCF_ASSERT_NEXT(a_seed_sticky, out_tvalid && out_tready && out_tuser, !(out_tvalid && !out_tuser))
  // fused angles read zero before seeding
  `TCF_ASSERT_NOW(a_unseeded_zero, out_tvalid && !out_tuser, out_tdata[62:31] == 32'd0)
  // accelerometer roll stays within half a turn
  `TCF_ASSERT_NOW(a_roll_range, out_tvalid, ($signed(out_tdata[15:0]) <= 16'sd23040) && ($signed(out_tdata[15:0]) >= -16'sd23040))

endmodule

// ===== rtl/tcf_front.sv =====
module tcf_front import tcf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign push       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/tcf_isqrt.sv =====
module tcf_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  output logic               done,
  output logic [29:0]        root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [59:0] n_r;
  logic [31:0] rem_r;
  logic [29:0] root_r;
  logic [31:0] ss;
  logic [33:0] rem2, test;

  assign ss   = 32'(ay * ay) + 32'(az * az);
  assign rem2 = {rem_r, n_r[59:58]};
  assign test = {2'b00, root_r, 2'b01};
  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= {ss, 28'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= n_r << 2;
      if (rem2 >= test) begin
        rem_r  <= 32'(rem2 - test);
        root_r <= {root_r[28:0], 1'b1};
      end else begin
        rem_r  <= rem2[31:0];
        root_r <= {root_r[28:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd29) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tcf_cordic.sv =====
module tcf_cordic import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cordic_req_t        req,
  output logic               done,
  output logic signed [15:0] angle
);

  localparam int AW = ANGLE_BITS + 2;
  localparam int PW = AW + 18;
  localparam logic signed [AW-1:0] QUARTER = AW'(1) << (ANGLE_BITS - 2);
  localparam logic [PW-1:0]        HALF    = PW'(1) << (ANGLE_BITS - 1);

  cordic_state_t        state_r, state_nxt;
  logic signed [XW-1:0] x_r, y_r, dx, dy;
  logic signed [AW-1:0] acc_r, ent;
  logic signed [PW-1:0] prod_r;
  logic [4:0]           it_r;
  logic [14:0]          lim_r, m15;
  logic                 zero_r, done_r, neg;
  logic [PW-1:0]        mag, rnd;
  logic signed [15:0]   angle_r, angle_v;

  assign dx  = y_r >>> it_r;
  assign dy  = x_r >>> it_r;
  assign ent = AW'(atan_entry(it_r, ANGLE_BITS));

  assign neg     = prod_r[PW-1];
  assign mag     = neg ? PW'(-prod_r) : PW'(prod_r);
  assign rnd     = (mag + HALF) >> ANGLE_BITS;
  assign m15     = (rnd > PW'(lim_r)) ? lim_r : rnd[14:0];
  assign angle_v = neg ? (16'sd0 - 16'({1'b0, m15})) : 16'({1'b0, m15});

  assign done  = done_r;
  assign angle = angle_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (req.start) state_nxt = C_ITER;
      C_ITER: if (it_r == 5'(CORDIC_STEPS - 1)) state_nxt = C_MUL;
      C_MUL:  state_nxt = C_RND;
      C_RND:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: if (req.start) begin
        zero_r <= (req.x == '0) && (req.y == '0);
        lim_r  <= req.lim;
        it_r   <= '0;
        // fold the left half plane onto the right
        if (req.x < 0) begin
          if (req.y >= 0) begin
            x_r <= req.y; y_r <= -req.x; acc_r <= QUARTER;
          end else begin
            x_r <= -req.y; y_r <= req.x; acc_r <= -QUARTER;
          end
        end else begin
          x_r <= req.x; y_r <= req.y; acc_r <= '0;
        end
      end
      C_ITER: begin
        if (y_r > 0) begin
          x_r <= x_r + dx; y_r <= y_r - dy; acc_r <= acc_r + ent;
        end else begin
          x_r <= x_r - dx; y_r <= y_r + dy; acc_r <= acc_r - ent;
        end
        it_r <= it_r + 5'd1;
      end
      C_MUL: prod_r <= PW'(acc_r) * PW'(DEG_SCALE);
      C_RND: angle_r <= zero_r ? 16'sd0 : angle_v;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= (state_r == C_RND);
  end

endmodule

// ===== rtl/tcf_blend.sv =====
module tcf_blend import tcf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] fused,
  input  logic signed [15:0] rate,
  input  logic signed [15:0] accel,
  input  logic [15:0]        dt,
  input  logic [16:0]        alpha,
  input  logic [2:0]         range_code,
  output logic               done,
  output logic signed [15:0] est
);

  blend_state_t       state_r, state_nxt;
  logic signed [33:0] ma, t_r;
  logic signed [17:0] mb;
  logic signed [51:0] p_r;
  logic signed [59:0] s_r;
  logic [59:0]        mag, r;
  logic               neg, done_r;
  logic signed [15:0] est_r, est_v;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      BL_AF: begin ma = 34'(fused); mb = {1'b0, alpha}; end
      BL_AA: begin ma = 34'(accel); mb = {1'b0, 17'(ALPHA_ONE - alpha)}; end
      BL_AR: begin ma = 34'(rate);  mb = {1'b0, alpha}; end
      BL_DT: begin ma = p_r[33:0];  mb = {2'b00, dt}; end
      default: ;
    endcase
  end

  assign neg = s_r[59];
  assign mag = neg ? 60'(-s_r) : 60'(s_r);
  assign r   = (mag + (60'd1 << 39)) >> 40;

  always_comb begin
    if (neg) est_v = (r > 60'd32768) ? -16'sd32768 : 16'sd0 - 16'(r);
    else     est_v = (r > 60'd32767) ? 16'sd32767 : 16'(r);
  end

  assign done = done_r;
  assign est  = est_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BL_IDLE: if (start) state_nxt = BL_AF;
      BL_AF:   state_nxt = BL_AA;
      BL_AA:   state_nxt = BL_AR;
      BL_AR:   state_nxt = BL_DT;
      BL_DT:   state_nxt = BL_SUM;
      BL_SUM:  state_nxt = BL_RND;
      BL_RND:  state_nxt = BL_IDLE;
      default: state_nxt = BL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BL_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == BL_RND);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BL_AF:  p_r <= ma * mb;
      BL_AA:  begin t_r <= p_r[33:0];          p_r <= ma * mb; end
      BL_AR:  begin t_r <= t_r + p_r[33:0];    p_r <= ma * mb; end
      BL_DT:  p_r <= ma * mb;
      BL_SUM: s_r <= (60'(t_r) <<< 24) + (60'(p_r) <<< range_code);
      BL_RND: est_r <= est_v;
      default: ;
    endcase
  end

endmodule

// ===== rtl/tcf_back.sv =====
module tcf_back import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  input  logic [16:0] alpha,
  input  logic [2:0]  gyro_range,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tuser
);

  back_state_t        state_r, state_nxt;
  item_t              item_r;
  cordic_req_t        creq;
  logic               c_done, sq_start, sq_done, bl_start, bl_done, dr, dp;
  logic signed [15:0] c_angle, roll_r, est_roll_r, est_pitch_r, br, bp;
  logic [14:0]        pitch_r;
  logic [29:0]        hyp_r, sq_root;
  logic               roll_ok_r, hyp_ok_r, seeded_r;
  logic               out_valid_r, out_user_r, emit;
  logic [63:0]        out_data_r;

  tcf_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk, .rst_n, .req(creq), .done(c_done), .angle(c_angle)
  );

  tcf_isqrt u_isqrt (
    .clk, .rst_n, .start(sq_start), .ay(item_r.accel_y), .az(item_r.accel_z),
    .done(sq_done), .root(sq_root)
  );

  tcf_blend u_blend_roll (
    .clk, .rst_n, .start(bl_start), .fused(est_roll_r), .rate(item_r.gyro_x_raw),
    .accel(roll_r), .dt(item_r.step_time), .alpha, .range_code(gyro_range),
    .done(dr), .est(br)
  );

  tcf_blend u_blend_pitch (
    .clk, .rst_n, .start(bl_start), .fused(est_pitch_r), .rate(item_r.gyro_y_raw),
    .accel({pitch_r[14], pitch_r}), .dt(item_r.step_time), .alpha,
    .range_code(gyro_range), .done(dp), .est(bp)
  );

  assign bl_done = dr && dp;
  assign emit    = (state_r == K_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    creq      = '0;
    sq_start  = 1'b0;
    bl_start  = 1'b0;
    case (state_r)
      K_IDLE: if (head_valid) begin
        pop       = 1'b1;
        state_nxt = K_ROLL_GO;
      end
      K_ROLL_GO: begin
        creq.start = 1'b1;
        creq.y     = prescale(item_r.accel_y);
        creq.x     = prescale(item_r.accel_z);
        creq.lim   = ROLL_LIM;
        sq_start   = 1'b1;
        state_nxt  = K_ROLL;
      end
      K_ROLL: if ((roll_ok_r || c_done) && (hyp_ok_r || sq_done)) state_nxt = K_PITCH_GO;
      K_PITCH_GO: begin
        creq.start = 1'b1;
        creq.y     = -prescale(item_r.accel_x);
        creq.x     = XW'(hyp_r);
        creq.lim   = PITCH_LIM;
        state_nxt  = K_PITCH;
      end
      K_PITCH: if (c_done) state_nxt = K_FUSE;
      K_FUSE: begin
        if ((item_r.step_time != 16'd0) && seeded_r) begin
          bl_start  = 1'b1;
          state_nxt = K_BLEND;
        end else begin
          state_nxt = K_EMIT;
        end
      end
      K_BLEND: if (bl_done) state_nxt = K_EMIT;
      K_EMIT:  if (emit) state_nxt = K_IDLE;
      default: state_nxt = K_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head;
    if (state_r == K_ROLL && c_done) roll_r <= c_angle;
    if (state_r == K_PITCH && c_done) pitch_r <= c_angle[14:0];
    if (sq_done) hyp_r <= sq_root;
    if (emit) begin
      out_data_r <= {1'b0, est_pitch_r, est_roll_r, pitch_r, roll_r};
      out_user_r <= seeded_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= K_IDLE;
      roll_ok_r   <= 1'b0;
      hyp_ok_r    <= 1'b0;
      seeded_r    <= 1'b0;
      est_roll_r  <= '0;
      est_pitch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == K_ROLL_GO) begin
        roll_ok_r <= 1'b0;
        hyp_ok_r  <= 1'b0;
      end else begin
        if (state_r == K_ROLL && c_done) roll_ok_r <= 1'b1;
        if (sq_done) hyp_ok_r <= 1'b1;
      end
      if (state_r == K_FUSE && item_r.step_time != 16'd0 && !seeded_r) begin
        est_roll_r  <= roll_r;
        est_pitch_r <= {pitch_r[14], pitch_r};
        seeded_r    <= 1'b1;
      end
      if (state_r == K_BLEND && bl_done) begin
        est_roll_r  <= br;
        est_pitch_r <= bp;
      end
      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sim/tcf_tilt_checker.sv =====
module tcf_tilt_checker import tcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [16:0] cfg_wr_data,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               seeded;
    logic signed [15:0] fused_pitch;
    logic signed [15:0] fused_roll;
    logic signed [14:0] accel_pitch;
    logic signed [15:0] accel_roll;
  } tilt_result_t;

  tilt_result_t tilt_expected_q[$];

  logic [16:0]        alpha_w;
  logic [2:0]         range_code;
  logic signed [15:0] roll_est;
  logic signed [15:0] pitch_est;
  logic               is_seeded;

  function automatic longint round_away(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return longint'(root);
  endfunction

  // vectoring CORDIC, 16 steps, 2^16 binary angle units per turn, 1/128 deg out
  function automatic longint tilt_atan2(longint y, longint x);
    longint acc, t, dx, dy, step_ang;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 64'sd1 << 14;
      end else begin
        t = x; x = -y; y = t; acc = -(64'sd1 << 14);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step_ang = (longint'(ATAN_TURN32[i]) + 64'sd32768) >>> 16;
      if (y > 0) begin
        x += dx; y -= dy; acc += step_ang;
      end else begin
        x -= dx; y += dy; acc -= step_ang;
      end
    end
    return round_away(acc * 46080, 16);
  endfunction

  function automatic longint fuse(longint est, longint gyro, longint acc_ang, longint a);
    longint g, s;
    g = est * (64'sd1 << 24) + gyro;
    s = a * g + (65536 - a) * (acc_ang * (64'sd1 << 24));
    return sat(round_away(s, 40), -32768, 32767);
  endfunction

  task automatic predict_sample(logic [95:0] d);
    longint ax, ay, az, gx, gy, dt, roll, pitch, hyp, a, sc;
    tilt_result_t r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    dt = longint'(d[95:80]);
    roll  = sat(tilt_atan2(ay <<< 14, az <<< 14), -23040, 23040);
    hyp   = floor_sqrt(longint'(ay * ay + az * az) << 28);
    pitch = sat(tilt_atan2((-ax) <<< 14, hyp), -11520, 11520);
    if (dt != 0) begin
      if (!is_seeded) begin
        roll_est  = 16'(roll);
        pitch_est = 16'(pitch);
        is_seeded = 1'b1;
      end else begin
        a  = (alpha_w > 17'd65536) ? 65536 : longint'(alpha_w);
        sc = 64'sd1 << range_code;
        roll_est  = 16'(fuse(roll_est, gx * dt * sc, roll, a));
        pitch_est = 16'(fuse(pitch_est, gy * dt * sc, pitch, a));
      end
    end
    r.accel_roll  = 16'(roll);
    r.accel_pitch = 15'(pitch);
    r.fused_roll  = is_seeded ? roll_est : '0;
    r.fused_pitch = is_seeded ? pitch_est : '0;
    r.seeded      = is_seeded;
    tilt_expected_q.push_back(r);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  initial errors = 0;
  initial outstanding = 0;

  always @(posedge clk) begin
    tilt_result_t e, got;
    if (!rst_n) begin
      alpha_w    = BLEND_RESET;
      range_code = '0;
      roll_est   = '0;
      pitch_est  = '0;
      is_seeded  = 1'b0;
      tilt_expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == REG_BLEND) alpha_w = cfg_wr_data;
        else if (cfg_addr == REG_RANGE) range_code = cfg_wr_data[2:0];
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata);
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[62:0]};
        if (tilt_expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $realtime, got);
        end else begin
          e = tilt_expected_q.pop_front();
          check_field("accel_roll", e.accel_roll, got.accel_roll);
          check_field("accel_pitch", e.accel_pitch, got.accel_pitch);
          check_field("fused_roll", e.fused_roll, got.fused_roll);
          check_field("fused_pitch", e.fused_pitch, got.fused_pitch);
          check_field("seeded", e.seeded, got.seeded);
          check_field("pad", 0, out_tdata[63]);
        end
      end
    end
    outstanding = tilt_expected_q.size();
  end
endmodule

// ===== sim/tb_imu_tilt_complementary_filter_top.sv =====
module tb_imu_tilt_complementary_filter_top;
  import tcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // accel_x, accel_y, accel_z, gyro_x_raw, gyro_y_raw, step_time
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // accel_roll, accel_pitch, fused_roll, fused_pitch, zero pad
  logic        out_tuser;       // seeded
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_addr = REG_BLEND;
  logic [16:0] cfg_wr_data = '0;

  int errors, outstanding;
  int results_seen = 0;
  int samples_sent = 0;
  bit steady_mode = 0;    // no idling on either side
  bit hold_off_req = 0;   // ask the receiver for a long stall

  always #10 clk = ~clk;

  imu_tilt_complementary_filter_top i_dut (.*);

  tcf_tilt_checker i_checker (.*);

  always @(posedge clk) if (out_tvalid && out_tready) results_seen++;

  // Receiver: random backpressure, plus a long counted hold-off on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_cnt == 0) begin
        hold_cnt = 400;
        hold_off_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady_mode || ($urandom_range(99) >= 37);
      end
    end
  end

  // Hand one sample to the block; hold valid until the request is taken.
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic signed [15:0] gx,
                             logic signed [15:0] gy, logic [15:0] dt);
    if (!steady_mode && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dt, gy, gx, az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Drain everything, then allow the block's own latency before touching registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  task automatic set_filter(logic [16:0] alpha, logic [2:0] range);
    write_reg(REG_BLEND, alpha);
    write_reg(REG_RANGE, {14'd0, range});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a plausible gravity vector with modest rates; sometimes raw noise.
  task automatic random_sample();
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [15:0] dt;
    if ($urandom_range(99) < 75) begin
      ax = 16'($signed($urandom_range(16384)) - 8192);
      ay = 16'($signed($urandom_range(16384)) - 8192);
      az = 16'($signed($urandom_range(16384)) - 8192);
      gx = 16'($signed($urandom_range(4000)) - 2000);
      gy = 16'($signed($urandom_range(4000)) - 2000);
      dt = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(2000, 500));
    end else begin
      {ax, ay, az} = 48'({$urandom, $urandom});
      {gx, gy, dt} = 48'({$urandom, $urandom});
    end
    send_sample(ax, ay, az, gx, gy, dt);
  endtask

  initial begin
    #20_000_000;
    $display("tb_imu_tilt_complementary_filter_top failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero step before seeding, then seed, extremes, special vectors.
    send_sample(16'sd0, 16'sd100, 16'sd16384, 16'sd50, -16'sd50, 16'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1000);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd10, 16'sd10, 16'd0);
    send_sample(-16'sd32768, 16'sd0, -16'sd32768, 16'sd32767, -16'sd32768, 16'd65535);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'd65535);
    send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1);
    send_sample(-16'sd32768, -16'sd32768, -16'sd1, 16'sd0, 16'sd0, 16'd1);
    send_sample(16'sd0, -16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'd2);
    send_sample(16'sd5, 16'sd0, -16'sd1, -16'sd1, 16'sd1, 16'd32768);
    send_sample(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    drain();

    // Gyro only at the widest range: drive the fused angles into saturation.
    set_filter(17'd65536, 3'd7);
    repeat (12) send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 16'd65535);
    drain();

    // Accelerometer only, then alpha above one.
    set_filter(17'd0, 3'd0);
    repeat (4) random_sample();
    drain();
    set_filter(17'h1FFFF, 3'd3);
    repeat (4) random_sample();
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1;
    repeat (20) random_sample();
    drain();

    // Random phases, each with its own setting; one phase with no idling.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) set_filter(BLEND_RESET, 3'd0);
      else set_filter(17'($urandom_range(70000)), 3'($urandom_range(7)));
      steady_mode = (phase == 3);
      repeat (120) random_sample();
      steady_mode = 0;
      drain();
    end

    $display("%0d samples sent, %0d results checked over several blend/range settings",
             samples_sent, results_seen);
    $display("covered seeding, zero steps, saturation and long output stalls");
    if (errors == 0 && outstanding == 0) begin
      $display("tb_imu_tilt_complementary_filter_top passed");
    end else begin
      $display("tb_imu_tilt_complementary_filter_top failed");
    end
    $finish;
  end
endmodule
